@@ rtl/tvp_pkg.sv @@
// Shared types, constants and the square-root digit step of the velocity profile.
`timescale 1ns / 1ps

package tvp_pkg;

  // Register map: register index is paddr[3:2].
  typedef enum logic [1:0] {
    REG_ACCEL  = 2'd0,
    REG_CRUISE = 2'd1,
    REG_FLOOR  = 2'd2,
    REG_LENGTH = 2'd3
  } reg_idx_e;

  localparam logic [31:0] AccelReset  = 32'd65536;
  localparam logic [31:0] CruiseReset = 32'd65536;
  localparam logic [31:0] FloorReset  = 32'd655;
  localparam logic [31:0] MagMax      = 32'h7FFF_FFFF;

  // 64-bit radicand, 32-bit root, two root bits per pipeline stage.
  localparam int unsigned RootBits = 32;
  localparam int unsigned SqStages = RootBits / 2;

  // Partial remainder and root of a bit-pair square root.
  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
  } sq_state_t;

  // One digit of the floor square root: bring down a bit pair, try root*4+1.
  function automatic sq_state_t sqrt_step(sq_state_t s, logic [1:0] pair);
    sq_state_t  r;
    logic [34:0] cur;
    logic [34:0] trial;
    cur   = {s.rem[32:0], pair};
    trial = {1'b0, s.root, 2'b01};
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

@@ rtl/trapezoidal_velocity_profile.sv @@
// Top level: register file, profile setup sequencer and velocity pipeline.
`timescale 1ns / 1ps

// Position-indexed trapezoidal velocity profile.
// Configure acceleration, cruise speed, floor speed and move length over the
// APB port (byte addresses 0, 4, 8, 12); pready is always high and reads
// return the stored values. Every register write starts a setup pass that
// derives the ramp length and the peak speed: a multiply step, a restoring
// divide, a clamp step and, for a triangular profile, one more multiply
// step and a square root. busy_o is high during the pass and also right
// after reset, which starts the same pass. Once busy_o is low, start_i with
// progress_pos_i launches one beat per cycle.
// Each beat runs through a select stage, a multiplier stage and a 16-stage
// square-root pipeline (two root bits per stage) plus an output register:
// done_o pulses with speed_cmd_o once the beat has passed them all, in
// order, one result per beat. The receiver cannot stall, so results show for
// exactly one cycle. Reset clears all valid bits and restores register
// defaults.
module trapezoidal_velocity_profile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] progress_pos_i,
  output logic        done_o,
  output logic [31:0] speed_cmd_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tvp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_CLAMP, S_PMUL, S_SQRT
  } setup_e;

  // Configuration registers
  logic [30:0] accel_q, cruise_q, floor_q;
  logic [31:0] length_q;
  logic        wr_en;
  reg_idx_e    wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_e'(paddr[3:2]);

  // Write registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q  <= AccelReset[30:0];
      cruise_q <= CruiseReset[30:0];
      floor_q  <= FloorReset[30:0];
      length_q <= '0;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_ACCEL:  accel_q  <= pwdata[30:0];
        REG_CRUISE: cruise_q <= pwdata[30:0];
        REG_FLOOR:  floor_q  <= pwdata[30:0];
        REG_LENGTH: length_q <= pwdata;
        default:    accel_q  <= accel_q;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (wr_idx)
      REG_ACCEL:  prdata = {1'b0, accel_q};
      REG_CRUISE: prdata = {1'b0, cruise_q};
      REG_FLOOR:  prdata = {1'b0, floor_q};
      REG_LENGTH: prdata = length_q;
      default:    prdata = '0;
    endcase
  end

  // Setup sequencer: ramp = v*v/(2a), clamp to |d|/2; peak = v, or isqrt(2a*ramp) when clamped
  setup_e      state_q;
  logic [32:0] div_rem_q;
  logic [61:0] div_num_q;
  logic [5:0]  cnt_q;
  logic [31:0] dist_q;
  logic [30:0] ramp_q;
  logic [31:0] peak_q;
  logic [63:0] cfg_n_q;
  sq_state_t   cfg_sq_q;
  sq_state_t   cfg_sq_d;

  logic [31:0] den;
  logic [32:0] div_try;
  logic        div_ge;
  logic [31:0] dist_abs;
  logic [30:0] half;

  assign den      = {accel_q, 1'b0};
  assign div_try  = {div_rem_q[31:0], div_num_q[61]};
  assign div_ge   = div_try >= {1'b0, den};
  assign dist_abs = length_q[31] ? (32'd0 - length_q) : length_q;
  assign half     = dist_abs[31:1];
  assign cfg_sq_d = sqrt_step(cfg_sq_q, cfg_n_q[63:62]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_MUL;
      div_rem_q <= '0;
      div_num_q <= '0;
      cnt_q     <= '0;
      dist_q    <= '0;
      ramp_q    <= '0;
      peak_q    <= '0;
      cfg_n_q   <= '0;
      cfg_sq_q  <= '0;
    end else if (wr_en) begin
      state_q <= S_MUL;
    end else begin
      unique case (state_q)
        S_IDLE: state_q <= S_IDLE;
        S_MUL: begin
          div_num_q <= 62'(cruise_q) * 62'(cruise_q);
          div_rem_q <= '0;
          cnt_q     <= '0;
          state_q   <= S_DIV;
        end
        S_DIV: begin
          // One quotient bit per cycle
          div_rem_q <= div_ge ? (div_try - {1'b0, den}) : div_try;
          div_num_q <= {div_num_q[60:0], div_ge};
          cnt_q     <= cnt_q + 6'd1;
          if (cnt_q == 6'd61) state_q <= S_CLAMP;
        end
        S_CLAMP: begin
          dist_q <= dist_abs;
          if (div_num_q > {31'd0, half}) begin
            ramp_q  <= half;
            state_q <= S_PMUL;
          end else begin
            ramp_q  <= div_num_q[30:0];
            peak_q  <= {1'b0, cruise_q};
            state_q <= S_IDLE;
          end
        end
        S_PMUL: begin
          cfg_n_q  <= 64'(den) * 64'(ramp_q);
          cfg_sq_q <= '0;
          cnt_q    <= '0;
          state_q  <= S_SQRT;
        end
        S_SQRT: begin
          // One root bit per cycle; latch the peak on the last one
          cfg_sq_q <= cfg_sq_d;
          cfg_n_q  <= {cfg_n_q[61:0], 2'b00};
          cnt_q    <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) begin
            peak_q  <= cfg_sq_d.root;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // Select stage: pick phase and square-root argument
  logic        take;
  logic [31:0] prog, rem_c, x_c;
  logic        cru_c;
  logic        s0_vld_q, s0_cru_q, s0_neg_q;
  logic [31:0] s0_x_q;

  assign take  = start_i && !busy_o;
  assign prog  = progress_pos_i[31] ? (32'd0 - progress_pos_i) : progress_pos_i;
  assign rem_c = (dist_q >= prog) ? (dist_q - prog) : (prog - dist_q);

  always_comb begin
    cru_c = 1'b0;
    x_c   = rem_c;
    if (prog < {1'b0, ramp_q}) begin
      x_c = prog;
    end else if (rem_c > {1'b0, ramp_q}) begin
      cru_c = 1'b1;
    end
  end

  // Multiplier stage
  logic        s1_vld_q, s1_cru_q, s1_neg_q;
  logic [63:0] s1_n_q;

  // Square-root stages, two digits each
  sq_state_t   sq_q     [SqStages];
  logic [63:0] sq_n_q   [SqStages];
  logic        sq_vld_q [SqStages];
  logic        sq_cru_q [SqStages];
  logic        sq_neg_q [SqStages];
  sq_state_t   sq_d     [SqStages];
  logic [63:0] sq_n_d   [SqStages];

  always_comb begin
    for (int k = 0; k < SqStages; k++) begin
      sq_state_t   s_in;
      logic [63:0] n_in;
      s_in = (k == 0) ? sq_state_t'('0) : sq_q[(k == 0) ? 0 : k - 1];
      n_in = (k == 0) ? s1_n_q : sq_n_q[(k == 0) ? 0 : k - 1];
      sq_d[k]   = sqrt_step(sqrt_step(s_in, n_in[63:62]), n_in[61:60]);
      sq_n_d[k] = {n_in[59:0], 4'b0000};
    end
  end

  // Output stage signals
  logic [31:0] mag, mag_fl;
  logic        out_vld_q;
  logic [31:0] out_q;

  always_comb begin
    mag    = sq_cru_q[SqStages-1] ? peak_q : sq_q[SqStages-1].root;
    mag_fl = (mag < {1'b0, floor_q}) ? {1'b0, floor_q} : mag;
    if (mag_fl > MagMax) mag_fl = MagMax;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k < SqStages; k++) sq_vld_q[k] <= 1'b0;
    end else begin
      s0_vld_q  <= take;
      s1_vld_q  <= s0_vld_q;
      sq_vld_q[0] <= s1_vld_q;
      for (int k = 1; k < SqStages; k++) sq_vld_q[k] <= sq_vld_q[k-1];
      out_vld_q <= sq_vld_q[SqStages-1];
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    s0_x_q   <= x_c;
    s0_cru_q <= cru_c;
    s0_neg_q <= $signed(length_q) < $signed(progress_pos_i);
    s1_n_q   <= 64'(den) * 64'(s0_x_q);
    s1_cru_q <= s0_cru_q;
    s1_neg_q <= s0_neg_q;
    sq_cru_q[0] <= s1_cru_q;
    sq_neg_q[0] <= s1_neg_q;
    for (int k = 1; k < SqStages; k++) begin
      sq_cru_q[k] <= sq_cru_q[k-1];
      sq_neg_q[k] <= sq_neg_q[k-1];
    end
    for (int k = 0; k < SqStages; k++) begin
      sq_q[k]   <= sq_d[k];
      sq_n_q[k] <= sq_n_d[k];
    end
    out_q <= sq_neg_q[SqStages-1] ? (32'd0 - mag_fl) : mag_fl;
  end

  assign done_o      = out_vld_q;
  assign speed_cmd_o = out_q;

  // Fixed latency from accepted beat to result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##19 done_o)
    else $error("result missing 19 cycles after accepted beat");

  // Any register write restarts the setup pass
  a_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite) |=> busy_o)
    else $error("register write did not start setup");

  // Saturation keeps the most negative code out
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (speed_cmd_o != 32'h8000_0000))
    else $error("speed not saturated");

endmodule

@@ tb/tb_trapezoidal_velocity_profile.sv @@
// Self-checking testbench for the trapezoidal velocity profile block.
`timescale 1ns / 1ps

module tb_trapezoidal_velocity_profile;
  import tvp_pkg::*;

  localparam int unsigned PipeLat    = 19;
  localparam int unsigned StallLimit = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [31:0] progress_pos_i;
  logic        done_o;
  logic [31:0] speed_cmd_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the move registers
  logic [30:0] accel_q;
  logic [30:0] cruise_q;
  logic [30:0] floor_q;
  logic [31:0] length_q;

  logic [31:0] speed_queue[$];
  int          fail_cnt;
  int          idle_cnt;
  bit          no_gaps;

  trapezoidal_velocity_profile dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .progress_pos_i, .done_o, .speed_cmd_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Commanded velocity for one progress sample under the current move
  function automatic logic [31:0] profile_speed(logic [31:0] pos);
    logic signed [63:0] d;
    logic signed [63:0] p;
    logic [63:0] dist_v, prog, remn, ramp, peak, spd, a;
    d      = $signed(length_q);
    p      = $signed(pos);
    dist_v = d < 0 ? -d : d;
    prog   = p < 0 ? -p : p;
    remn   = dist_v >= prog ? dist_v - prog : prog - dist_v;
    a      = {33'd0, accel_q};
    if (a == 0) ramp = '1;
    else ramp = ({33'd0, cruise_q} * {33'd0, cruise_q}) / (2 * a);
    if (ramp > dist_v / 2) begin
      ramp = dist_v >> 1;
      peak = floor_root(2 * a * ramp);
    end else begin
      peak = {33'd0, cruise_q};
    end
    if (prog < ramp) spd = floor_root(2 * a * prog);
    else if (remn > ramp) spd = peak;
    else spd = floor_root(2 * a * remn);
    if (spd < {33'd0, floor_q}) spd = {33'd0, floor_q};
    if (spd > 64'h7FFF_FFFF) spd = 64'h7FFF_FFFF;
    return (d - p) < 0 ? -spd[31:0] : spd[31:0];
  endfunction

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (speed_queue.size() == 0) begin
        $display("%0t: unexpected speed beat, actual %h", $time, speed_cmd_o);
        fail_cnt++;
      end else begin
        if (speed_queue[0] !== speed_cmd_o) begin
          $display("%0t: speed_cmd mismatch, expected %h actual %h",
                   $time, speed_queue[0], speed_cmd_o);
          fail_cnt++;
        end
        void'(speed_queue.pop_front());
      end
    end
  end

  // Watchdog: end the run if beats, results and APB idle too long
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o) || (psel && penable)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt > StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Drop start, then wait until every beat has come back
  task automatic wait_drained();
    start_i <= 1'b0;
    while (speed_queue.size() != 0) @(posedge clk_i);
    repeat (PipeLat + 4) @(posedge clk_i);
  endtask

  // Write one register: setup then access, then wait for the setup pass
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ACCEL:  accel_q  = value[30:0];
      REG_CRUISE: cruise_q = value[30:0];
      REG_FLOOR:  floor_q  = value[30:0];
      default:    length_q = value;
    endcase
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic set_move(logic [31:0] a, logic [31:0] v, logic [31:0] f,
                          logic [31:0] d);
    wait_drained();
    write_reg(REG_ACCEL, a);
    write_reg(REG_CRUISE, v);
    write_reg(REG_FLOOR, f);
    write_reg(REG_LENGTH, d);
  endtask

  // Send one progress beat, with random gaps unless gaps are off
  task automatic send_pos(logic [31:0] pos);
    while (!no_gaps && $urandom_range(99) < 37) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    progress_pos_i <= pos;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    speed_queue.push_back(profile_speed(pos));
  endtask

  task automatic test_reset_defaults();
    send_pos(32'd0);
    send_pos(32'h7FFF_FFFF);
    send_pos(32'h8000_0000);
    send_pos(32'hFFFF_FFFF);
  endtask

  task automatic test_directed_edges();
    set_move(32'h0001_0000, 32'h0004_0000, 32'd655, 32'h0010_0000);
    send_pos(32'd0);
    send_pos(32'h0000_8000);
    send_pos(32'h0008_0000);
    send_pos(32'h0010_0000);
    send_pos(32'h0012_0000);
    // triangle profile
    set_move(32'h0000_4000, 32'h7FFF_FFFF, 32'd1, 32'hFFF0_0000);
    send_pos(32'hFFF8_0000);
    send_pos(32'h0000_0001);
    send_pos(32'hFFF0_0000);
    // zero acceleration, zero floor
    set_move(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
    send_pos(32'h4000_0000);
    send_pos(32'h8000_0000);
    // saturating magnitude, all-ones register writes
    set_move(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_pos(32'h7FFF_FFFF);
    send_pos(32'h8000_0000);
    send_pos(32'd0);
    set_move(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF);
    send_pos(32'h0000_0100);
    send_pos(32'h3FFF_FFFF);
    send_pos(32'hC000_0000);
  endtask

  task automatic test_random_moves();
    for (int m = 0; m < 14; m++) begin
      set_move($urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(1, 32'h0010_0000),
               $urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(1, 32'h0100_0000),
               $urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(0, 32'h0001_0000),
               $urandom_range(0, 3) == 0 ? $urandom() :
               ($urandom_range(1) ? $urandom_range(0, 32'h0400_0000) :
                                    -$urandom_range(0, 32'h0400_0000)));
      no_gaps = (m == 5);
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(9) < 7)
          send_pos($signed(length_q) / 256 * $signed($urandom_range(0, 300)) -
                   $signed(length_q) / 256 * 10 * 0);
        else
          send_pos($urandom());
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    fail_cnt       = 0;
    idle_cnt       = 0;
    no_gaps        = 1'b0;
    accel_q        = 31'd65536;
    cruise_q       = 31'd65536;
    floor_q        = 31'd655;
    length_q       = 32'd0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    progress_pos_i = 32'd0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = 4'd0;
    pwdata         = 32'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    test_reset_defaults();
    test_directed_edges();
    test_random_moves();
    wait_drained();
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tvp_pkg.sv
rtl/trapezoidal_velocity_profile.sv
tb/tb_trapezoidal_velocity_profile.sv
